// File: hdl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// Hermite spline point evaluator package
// Sizes, beat types and helper functions shared by the evaluator modules.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 15;
  localparam int NUM_AXES    = 3;
  localparam int FIELD_W     = 48;
  localparam int PARAM_W     = 16;
  localparam int OUT_W       = 16;
  localparam int EXT_W       = 64;

  localparam int SQ_W   = 2 * PARAM_W;
  localparam int S2_W   = SQ_W - FRAC_BITS;
  localparam int CU_W   = S2_W + PARAM_W;
  localparam int S3_W   = CU_W - FRAC_BITS;
  localparam int MAX_A  = (S2_W > S3_W) ? S2_W : S3_W;
  localparam int MAX_B  = (MAX_A > FRAC_BITS) ? MAX_A : FRAC_BITS;
  localparam int H_W    = MAX_B + 4;
  localparam int PROD_W = COORD_WIDTH + H_W;
  localparam int SUM_W  = (PROD_W + 2 > FRAC_BITS + OUT_W) ? PROD_W + 2 : FRAC_BITS + OUT_W;

  localparam logic [H_W-1:0] ONE_Q = H_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [PARAM_W-1:0] param;
    logic [FIELD_W-1:0] start_point;
    logic [FIELD_W-1:0] end_point;
    logic [FIELD_W-1:0] start_tangent;
    logic [FIELD_W-1:0] end_tangent;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic signed [OUT_W-1:0] pos_z;
  } result_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start_point;
    logic [FIELD_W-1:0] end_point;
    logic [FIELD_W-1:0] start_tangent;
    logic [FIELD_W-1:0] end_tangent;
  } hsp_keys_t;

  typedef struct packed {
    logic signed [H_W-1:0] h0;
    logic signed [H_W-1:0] h1;
    logic signed [H_W-1:0] h2;
    logic signed [H_W-1:0] h3;
  } hsp_wts_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] b;
  } hsp_pair_t;

  // Extracts one signed coordinate; a coordinate past the 48-bit field reads as zero.
  function automatic logic signed [COORD_WIDTH-1:0] lane_of(input logic [FIELD_W-1:0] f,
                                                           input int k);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] sh;
    ext = EXT_W'(f);
    sh  = (k * COORD_WIDTH >= EXT_W) ? '0 : ext >> (k * COORD_WIDTH);
    return sh[COORD_WIDTH-1:0];
  endfunction

  // Arithmetic shift by the fraction width, wrapped to the coordinate width.
  function automatic logic [OUT_W-1:0] wrap_out(input logic signed [SUM_W-1:0] acc);
    logic [OUT_W-1:0] r;
    for (int j = 0; j < OUT_W; j++) begin
      r[j] = (j < COORD_WIDTH) ? acc[FRAC_BITS+j] : 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/hsp_basis.sv
// ----------------------------------------------------------------------------
// Hermite basis weight pipeline
// Three stages: s squared, s cubed, then the four Q15 basis weights.
// ----------------------------------------------------------------------------
module hsp_basis
  import hsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      item_valid,
  input  item_t     item,
  output logic      wvalid,
  output hsp_wts_t  wts,
  output hsp_keys_t keys
);

  logic                v1, v2;
  logic [PARAM_W-1:0]  s1, s2p;
  logic [SQ_W-1:0]     sq1;
  logic [S2_W-1:0]     s2;
  logic [CU_W-1:0]     cu2;
  hsp_keys_t           k1, k2;

  logic [S2_W-1:0]     s2_next;
  logic [S3_W-1:0]     s3;
  logic signed [H_W-1:0] e2, e3, es;
  hsp_wts_t            wts_next;

  assign s2_next = S2_W'(sq1 >> FRAC_BITS);
  assign s3      = S3_W'(cu2 >> FRAC_BITS);
  assign e2      = H_W'(s2);
  assign e3      = H_W'(s3);
  assign es      = H_W'(s2p);

  always_comb begin
    wts_next.h0 = (e3 <<< 1) - (e3 - e3) - (e2 + (e2 <<< 1)) + signed'(ONE_Q);
    wts_next.h1 = (e2 + (e2 <<< 1)) - (e3 <<< 1);
    wts_next.h2 = e3 - (e2 <<< 1) + es;
    wts_next.h3 = e3 - e2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      wvalid <= 1'b0;
    end else if (adv) begin
      v1     <= item_valid;
      v2     <= v1;
      wvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1   <= item.param;
      sq1  <= SQ_W'(item.param) * SQ_W'(item.param);
      k1   <= '{item.start_point, item.end_point, item.start_tangent, item.end_tangent};
      s2   <= s2_next;
      s2p  <= s1;
      cu2  <= CU_W'(s2_next) * CU_W'(s1);
      k2   <= k1;
      wts  <= wts_next;
      keys <= k2;
    end
  end

endmodule

// File: hdl/hsp_lane.sv
// ----------------------------------------------------------------------------
// Hermite axis lane
// Weights the four key values of one axis and adds them in pairs.
// ----------------------------------------------------------------------------
module hsp_lane
  import hsp_pkg::*;
(
  input  logic                          clk,
  input  logic                          adv,
  input  hsp_wts_t                      wts,
  input  logic signed [COORD_WIDTH-1:0] p0,
  input  logic signed [COORD_WIDTH-1:0] p1,
  input  logic signed [COORD_WIDTH-1:0] m0,
  input  logic signed [COORD_WIDTH-1:0] m1,
  output hsp_pair_t                     pair
);

  logic signed [PROD_W-1:0] prod0, prod1, prod2, prod3;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod0  <= PROD_W'(p0) * PROD_W'(wts.h0);
      prod1  <= PROD_W'(p1) * PROD_W'(wts.h1);
      prod2  <= PROD_W'(m0) * PROD_W'(wts.h2);
      prod3  <= PROD_W'(m1) * PROD_W'(wts.h3);
      pair.a <= SUM_W'(prod0) + SUM_W'(prod1);
      pair.b <= SUM_W'(prod2) + SUM_W'(prod3);
    end
  end

endmodule

// File: hdl/hermite_spline_point_eval.sv
// ----------------------------------------------------------------------------
// Hermite spline point evaluator
// An accepted input beat passes the basis stages, lane products, pair sums and result register.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds only while a result beat waits under stall.
// Reset clears all pipeline valid bits; no result beat is shown after reset.
// ----------------------------------------------------------------------------
module hermite_spline_point_eval
  import hsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic      adv;
  logic      wvalid;
  hsp_wts_t  wts;
  hsp_keys_t keys;
  logic      v4, v5;
  hsp_pair_t pairs [NUM_AXES];
  result_t   result_next;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  hsp_basis u_basis (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .wvalid     (wvalid),
    .wts        (wts),
    .keys       (keys)
  );

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    hsp_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .wts  (wts),
      .p0   (lane_of(keys.start_point, k)),
      .p1   (lane_of(keys.end_point, k)),
      .m0   (lane_of(keys.start_tangent, k)),
      .m1   (lane_of(keys.end_tangent, k)),
      .pair (pairs[k])
    );
  end

  always_comb begin
    result_next.pos_x = signed'(wrap_out(pairs[0].a + pairs[0].b));
    result_next.pos_y = signed'(wrap_out(pairs[1].a + pairs[1].b));
    result_next.pos_z = signed'(wrap_out(pairs[2].a + pairs[2].b));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v4           <= wvalid;
      v5           <= v4;
      result_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid && !v4 && !v5)
    else $error("pipeline valid bits not cleared by reset");

  a_last_stage_delivers: assert property (@(posedge clk) disable iff (rst)
    adv && v5 |=> result_valid)
    else $error("last lane stage did not reach the result register");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(v4) && $stable(v5) && $stable(wvalid))
    else $error("pipeline moved while the result beat was stalled");

endmodule
